// File: sv/rbq_pkg.sv
`default_nettype none

package rbq_pkg;

  // Fixed port widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CNT_W  = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_GET  = 2'd2;

  // Status reported with every result
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic             is_full;
    logic             dropped;
  } rbq_status_t;

endpackage

`default_nettype wire

// File: sv/ring_buffer_queue.sv
`default_nettype none

// Circular FIFO of VALUE_BITS-bit words with a read by offset from the head.
// A transaction is accepted on a clock edge with start high and busy low;
// busy is never raised, so a push, pop or get can be issued every cycle.
// Each transaction gives one result in the next cycle, shown for a single
// cycle with valid_o high; the receiver cannot stall and must take it then.
// The result is timed by the read port of the slot memory: pop and get
// addresses are formed in the accept cycle and the word comes back from the
// registered read. A push writes at the accept edge, so a pop or get in the
// very next cycle already sees it. Push on a full queue is dropped and
// flagged; pop on an empty queue and the unused op code change nothing and
// return zero. Get reads head plus index (mod CAPACITY) with no fill check:
// reading a slot never written returns undefined data. No clearing pass runs
// after reset; the block is ready at once.
module ring_buffer_queue #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [rbq_pkg::OP_W-1:0]   op_i,
  input  wire logic [rbq_pkg::DATA_W-1:0] data_in_i,
  input  wire logic [rbq_pkg::IDX_W-1:0]  index_i,
  output logic                            valid_o,
  output logic      [rbq_pkg::DATA_W-1:0] data_out_o,
  output logic      [rbq_pkg::CNT_W-1:0]  count_o,
  output logic                            is_empty_o,
  output logic                            is_full_o,
  output logic                            dropped_o
);

  import rbq_pkg::*;

  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FW = $clog2(CAPACITY + 1);

  logic                  accept;
  logic                  mem_we, mem_re, use_rdata;
  logic [PW-1:0]         mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;
  rbq_status_t           status;

  // one transaction per cycle, never held off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rbq_ctrl #(
    .CAPACITY (CAPACITY),
    .PW       (PW),
    .FW       (FW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .index_i     (index_i),
    .we_o        (mem_we),
    .waddr_o     (mem_waddr),
    .re_o        (mem_re),
    .raddr_o     (mem_raddr),
    .valid_o     (valid_o),
    .use_rdata_o (use_rdata),
    .status_o    (status)
  );

  rbq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_BITS),
    .AW    (PW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (data_in_i[VALUE_BITS-1:0]),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // push, empty pop and unused code return zero
  assign data_out_o = use_rdata ? DATA_W'(mem_rdata) : '0;
  assign count_o    = status.count;
  assign is_empty_o = status.is_empty;
  assign is_full_o  = status.is_full;
  assign dropped_o  = status.dropped;

endmodule

`default_nettype wire

// File: sv/rbq_mem.sv
`default_nettype none

module rbq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, updated only when re_i is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/rbq_ctrl.sv
`default_nettype none

module rbq_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned PW       = 6,
  parameter int unsigned FW       = 7
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [rbq_pkg::OP_W-1:0]  op_i,
  input  wire logic [rbq_pkg::IDX_W-1:0] index_i,
  output logic                           we_o,
  output logic      [PW-1:0]             waddr_o,
  output logic                           re_o,
  output logic      [PW-1:0]             raddr_o,
  output logic                           valid_o,
  output logic                           use_rdata_o,
  output rbq_pkg::rbq_status_t           status_o
);

  import rbq_pkg::*;

  localparam logic [PW-1:0] LAST_PTR = PW'(CAPACITY - 1);
  localparam logic [FW-1:0] FULL_CNT = FW'(CAPACITY);
  localparam logic [PW:0]   CAP_EXT  = (PW+1)'(CAPACITY);

  // index mod CAPACITY by restoring subtraction of shifted constants
  function automatic logic [PW-1:0] idx_mod(input logic [IDX_W-1:0] idx);
    int unsigned rem;
    rem = 32'(idx);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (rem >= (CAPACITY << k)) begin
        rem = rem - (CAPACITY << k);
      end
    end
    return PW'(rem);
  endfunction

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          valid_q, use_q, use_d;
  logic          dropped;
  logic [PW:0]   get_sum;
  logic [PW-1:0] get_addr;
  rbq_status_t   status_q, status_d;

  always_comb begin
    get_sum  = {1'b0, head_q} + {1'b0, idx_mod(index_i)};
    get_addr = (get_sum >= CAP_EXT) ? PW'(get_sum - CAP_EXT) : get_sum[PW-1:0];
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    fill_d  = fill_q;
    use_d   = 1'b0;
    dropped = 1'b0;
    we_o    = 1'b0;
    re_o    = 1'b0;
    raddr_o = head_q;
    if (accept_i) begin
      unique case (op_i)
        OP_PUSH: begin
          if (fill_q == FULL_CNT) begin
            dropped = 1'b1;
          end else begin
            we_o   = 1'b1;
            tail_d = ptr_next(tail_q);
            fill_d = fill_q + FW'(1);
          end
        end
        OP_POP: begin
          if (fill_q != '0) begin
            re_o   = 1'b1;
            use_d  = 1'b1;
            head_d = ptr_next(head_q);
            fill_d = fill_q - FW'(1);
          end
        end
        OP_GET: begin
          re_o    = 1'b1;
          use_d   = 1'b1;
          raddr_o = get_addr;
        end
        default: ;
      endcase
    end
  end

  assign waddr_o = tail_q;

  always_comb begin
    status_d.count    = CNT_W'(fill_d);
    status_d.is_empty = (fill_d == '0);
    status_d.is_full  = (fill_d == FULL_CNT);
    status_d.dropped  = dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
      valid_q <= 1'b0;
      use_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      valid_q <= accept_i;
      use_q   <= use_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      status_q <= status_d;
    end
  end

  assign valid_o     = valid_q;
  assign use_rdata_o = use_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// File: sv/rbq_checker.sv
`default_nettype none

module rbq_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       valid_o,
  input wire logic [rbq_pkg::DATA_W-1:0] data_out_o,
  input wire logic [rbq_pkg::CNT_W-1:0]  count_o,
  input wire logic                       is_empty_o,
  input wire logic                       is_full_o,
  input wire logic                       dropped_o
);

  import rbq_pkg::*;

  // every result comes in the cycle after an accepted transaction
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy))
    else $error("result without transaction");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_empty_o) |-> (count_o == '0))
    else $error("empty with nonzero count");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && dropped_o) |-> (is_full_o && !is_empty_o && data_out_o == '0))
    else $error("drop while not full");

  // a dropped push leaves the count as the previous result showed it
  a_drop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && dropped_o && $past(valid_o)) |-> (count_o == $past(count_o)))
    else $error("count moved on dropped push");

endmodule

bind ring_buffer_queue rbq_checker u_rbq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .valid_o    (valid_o),
  .data_out_o (data_out_o),
  .count_o    (count_o),
  .is_empty_o (is_empty_o),
  .is_full_o  (is_full_o),
  .dropped_o  (dropped_o)
);

`default_nettype wire
